// File: rtl/swerve_odometry_accumulator_core_defines.svh
// Assertion macros shared by the checker of the swerve odometry accumulator.
`ifndef SWERVE_ODOMETRY_ACCUMULATOR_CORE_DEFINES_SVH
`define SWERVE_ODOMETRY_ACCUMULATOR_CORE_DEFINES_SVH

// Combinational implication, sampled on the rising edge of aclk.
`define SOA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |-> (cons)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define SOA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/soa_pkg.sv
// Shared constants, types and the sine table generator for the odometry accumulator.
`timescale 1ns / 1ps

package soa_pkg;

    localparam int WHEEL_COUNT = 4;
    localparam int ANGLE_W     = 16;
    localparam int TRAVEL_W    = 16;
    localparam int POS_W       = 32;
    localparam int SIN_W       = 15;
    localparam int TRIG_W      = 16;
    localparam int PROD_W      = 32;
    localparam int SUM_W       = 34;
    localparam int DELTA_SHIFT = 17;
    localparam int DELTA_W     = SUM_W - DELTA_SHIFT;
    localparam int CFG_IDX_W   = 2;

    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'd16384;
    localparam logic [63:0]        HALF_PI_Q30  = 64'd1686629713;

    localparam logic [CFG_IDX_W-1:0] CFG_START_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 2'd1;

    // Denominators (2k)(2k+1) of the Taylor terms of sine, k = 1..7.
    localparam logic [63:0] TAYLOR_DIV [7] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
    };

    typedef struct packed {
        logic lookup;
        logic mult;
    } pipe_en_t;

    // Unsigned Q0.15 sine of an angle given in Q2.30 radians, evaluated at elaboration.
    function automatic logic [SIN_W-1:0] sine_entry(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [65:0] sum;
        logic signed [65:0] q;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed({2'b00, x});
        for (int k = 1; k <= 7; k++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[k-1];
            if (k[0]) begin
                sum = sum - $signed({2'b00, term});
            end else begin
                sum = sum + $signed({2'b00, term});
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        q = (sum + 66'sd16384) >>> 15;
        if (q > 66'sd32767) begin
            q = 66'sd32767;
        end
        return q[SIN_W-1:0];
    endfunction

endpackage

// File: rtl/swerve_odometry_accumulator_core.sv
// Swerve drive odometry accumulator: four wheel lanes, a merge stage and the position registers.
//
// Usage: each transaction on the s_axis channel carries one sensor sample (gyro heading,
// four wheel steering angles, four wheel travel deltas) and the clear flag in s_axis_tuser.
// For every sample one transaction leaves on m_axis with the updated X and Y positions.
// There are four register stages: angle lookup, wheel multiply, lane merge, then the
// accumulator add, whose result register is the output. The accepting edge loads the
// first stage; m_axis_tvalid rises once the sample reaches the output register.
// Throughput is one sample per cycle while m_axis_tready is high; the position register
// add loop allows it. Each stage has its own valid bit and moves when the stage after it is
// empty or moving, so the input keeps flowing while a result waits in the output register.
// When m_axis_tready stays low the stages fill up and s_axis_tready falls after three
// more samples. A write on the config port loads start_x or start_y straight into the
// position register; write only while the block is idle. Reset empties the pipeline and
// sets both positions to zero.
`timescale 1ns / 1ps

module swerve_odometry_accumulator_core #(
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // gyro_angle, wheel_angle_0..3, wheel_travel_0..3, 16 bits each, from bit 0 up.
    input  logic [143:0]                    s_axis_tdata,
    // clear_position.
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // field_x, field_y, 32 bits each, from bit 0 up.
    output logic [63:0]                     m_axis_tdata,
    input  logic                            cfg_wr_en,
    input  logic [soa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [soa_pkg::POS_W-1:0]       cfg_wdata
);

    localparam int AW = soa_pkg::ANGLE_W;
    localparam int NW = soa_pkg::WHEEL_COUNT;

    logic valid_a_reg;
    logic valid_b_reg;
    logic valid_c_reg;
    logic valid_d_reg;
    logic clear_a_reg;
    logic clear_b_reg;
    logic clear_c_reg;
    logic en_a;
    logic en_b;
    logic en_c;
    logic en_d;

    soa_pkg::pipe_en_t lane_en;

    logic [AW-1:0]                       gyro_angle;
    logic [AW-1:0]                       wheel_angle  [NW];
    logic signed [soa_pkg::TRAVEL_W-1:0] wheel_travel [NW];
    logic signed [soa_pkg::PROD_W-1:0]   prod_x       [NW];
    logic signed [soa_pkg::PROD_W-1:0]   prod_y       [NW];
    logic signed [soa_pkg::DELTA_W-1:0]  delta_x;
    logic signed [soa_pkg::DELTA_W-1:0]  delta_y;

    logic [soa_pkg::POS_W-1:0] pos_x_reg;
    logic [soa_pkg::POS_W-1:0] pos_y_reg;
    logic [soa_pkg::POS_W-1:0] pos_x_next;
    logic [soa_pkg::POS_W-1:0] pos_y_next;

    assign en_d = !valid_d_reg || m_axis_tready;
    assign en_c = !valid_c_reg || en_d;
    assign en_b = !valid_b_reg || en_c;
    assign en_a = !valid_a_reg || en_b;

    assign lane_en.lookup = en_a;
    assign lane_en.mult   = en_b;

    assign gyro_angle = s_axis_tdata[AW-1:0];
    for (genvar w = 0; w < NW; w++) begin : g_lane
        assign wheel_angle[w]  = s_axis_tdata[AW*(1+w) +: AW];
        assign wheel_travel[w] = $signed(s_axis_tdata[AW*(1+NW+w) +: AW]);

        soa_lane #(
            .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
        ) u_lane (
            .aclk         (aclk),
            .en           (lane_en),
            .gyro_angle   (gyro_angle),
            .wheel_angle  (wheel_angle[w]),
            .wheel_travel (wheel_travel[w]),
            .prod_x       (prod_x[w]),
            .prod_y       (prod_y[w])
        );
    end

    soa_merge u_merge (
        .aclk    (aclk),
        .en      (en_c),
        .prod_x  (prod_x),
        .prod_y  (prod_y),
        .delta_x (delta_x),
        .delta_y (delta_y)
    );

    always_comb begin
        pos_x_next = (clear_c_reg ? '0 : pos_x_reg) + soa_pkg::POS_W'(delta_x);
        pos_y_next = (clear_c_reg ? '0 : pos_y_reg) + soa_pkg::POS_W'(delta_y);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
        end else begin
            if (en_a) begin
                valid_a_reg <= s_axis_tvalid;
            end
            if (en_b) begin
                valid_b_reg <= valid_a_reg;
            end
            if (en_c) begin
                valid_c_reg <= valid_b_reg;
            end
            if (en_d) begin
                valid_d_reg <= valid_c_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en_a) begin
            clear_a_reg <= s_axis_tuser;
        end
        if (en_b) begin
            clear_b_reg <= clear_a_reg;
        end
        if (en_c) begin
            clear_c_reg <= clear_b_reg;
        end
    end

    // The position registers double as the output register of the result channel.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                soa_pkg::CFG_START_X: pos_x_reg <= cfg_wdata;
                soa_pkg::CFG_START_Y: pos_y_reg <= cfg_wdata;
                default: ;
            endcase
        end else if (en_d && valid_c_reg) begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
        end
    end

    assign s_axis_tready = en_a;
    assign m_axis_tvalid = valid_d_reg;
    assign m_axis_tdata  = {pos_y_reg, pos_x_reg};

endmodule

// File: rtl/soa_lane.sv
// One wheel lane: relative angle, quarter-wave sine and cosine lookup, travel products.
`timescale 1ns / 1ps

module soa_lane #(
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic                                aclk,
    input  soa_pkg::pipe_en_t                   en,
    input  logic [soa_pkg::ANGLE_W-1:0]         gyro_angle,
    input  logic [soa_pkg::ANGLE_W-1:0]         wheel_angle,
    input  logic signed [soa_pkg::TRAVEL_W-1:0] wheel_travel,
    output logic signed [soa_pkg::PROD_W-1:0]   prod_x,
    output logic signed [soa_pkg::PROD_W-1:0]   prod_y
);

    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int OFF_W = 15;
    localparam int MUL_W = OFF_W + IDX_W;

    logic [soa_pkg::SIN_W-1:0] sine_rom [SINE_TABLE_DEPTH+1];

    for (genvar gi = 0; gi <= SINE_TABLE_DEPTH; gi++) begin : g_rom
        assign sine_rom[gi] =
            soa_pkg::sine_entry((soa_pkg::HALF_PI_Q30 * 64'(gi)) / SINE_TABLE_DEPTH);
    end

    function automatic logic signed [soa_pkg::TRIG_W-1:0] trig_lookup(
        input logic [soa_pkg::ANGLE_W-1:0] a,
        input logic [soa_pkg::SIN_W-1:0]   rom [SINE_TABLE_DEPTH+1]
    );
        logic [1:0]                 quad;
        logic [OFF_W-1:0]           off;
        logic [MUL_W-1:0]           scaled;
        logic [IDX_W-1:0]           idx;
        logic [soa_pkg::TRIG_W-1:0] mag;
        quad   = a[15:14];
        off    = quad[0] ? (OFF_W'(soa_pkg::QUARTER_TURN) - {1'b0, a[13:0]})
                         : {1'b0, a[13:0]};
        scaled = MUL_W'(off) * MUL_W'(SINE_TABLE_DEPTH);
        idx    = scaled[IDX_W+13:14];
        mag    = {1'b0, rom[idx]};
        return quad[1] ? $signed(-mag) : $signed(mag);
    endfunction

    logic [soa_pkg::ANGLE_W-1:0]         rel;
    logic signed [soa_pkg::TRIG_W-1:0]   sin_reg;
    logic signed [soa_pkg::TRIG_W-1:0]   cos_reg;
    logic signed [soa_pkg::TRAVEL_W-1:0] travel_reg;
    logic signed [soa_pkg::PROD_W-1:0]   prod_x_reg;
    logic signed [soa_pkg::PROD_W-1:0]   prod_y_reg;

    assign rel = gyro_angle - wheel_angle;

    always_ff @(posedge aclk) begin
        if (en.lookup) begin
            sin_reg    <= trig_lookup(rel, sine_rom);
            cos_reg    <= trig_lookup(rel + soa_pkg::QUARTER_TURN, sine_rom);
            travel_reg <= wheel_travel;
        end
        if (en.mult) begin
            prod_x_reg <= sin_reg * travel_reg;
            prod_y_reg <= cos_reg * travel_reg;
        end
    end

    assign prod_x = prod_x_reg;
    assign prod_y = prod_y_reg;

endmodule

// File: rtl/soa_merge.sv
// Merging stage: sums the lane products and rounds them to position deltas.
`timescale 1ns / 1ps

module soa_merge (
    input  logic                               aclk,
    input  logic                               en,
    input  logic signed [soa_pkg::PROD_W-1:0]  prod_x [soa_pkg::WHEEL_COUNT],
    input  logic signed [soa_pkg::PROD_W-1:0]  prod_y [soa_pkg::WHEEL_COUNT],
    output logic signed [soa_pkg::DELTA_W-1:0] delta_x,
    output logic signed [soa_pkg::DELTA_W-1:0] delta_y
);

    localparam logic signed [soa_pkg::SUM_W-1:0] ROUND_HALF = 34'sd65536;

    logic signed [soa_pkg::SUM_W-1:0]   sum_x;
    logic signed [soa_pkg::SUM_W-1:0]   sum_y;
    logic signed [soa_pkg::SUM_W-1:0]   rnd_x;
    logic signed [soa_pkg::SUM_W-1:0]   rnd_y;
    logic signed [soa_pkg::DELTA_W-1:0] delta_x_reg;
    logic signed [soa_pkg::DELTA_W-1:0] delta_y_reg;

    always_comb begin
        sum_x = '0;
        sum_y = '0;
        for (int w = 0; w < soa_pkg::WHEEL_COUNT; w++) begin
            sum_x = sum_x + soa_pkg::SUM_W'(prod_x[w]);
            sum_y = sum_y - soa_pkg::SUM_W'(prod_y[w]);
        end
        // Dropping the low bits of the biased sum floors it, which rounds half up.
        rnd_x = sum_x + ROUND_HALF;
        rnd_y = sum_y + ROUND_HALF;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            delta_x_reg <= rnd_x[soa_pkg::SUM_W-1:soa_pkg::DELTA_SHIFT];
            delta_y_reg <= rnd_y[soa_pkg::SUM_W-1:soa_pkg::DELTA_SHIFT];
        end
    end

    assign delta_x = delta_x_reg;
    assign delta_y = delta_y_reg;

endmodule

// File: rtl/soa_checker.sv
// Port-level checker for the odometry accumulator, bound to the top level.
`timescale 1ns / 1ps
`include "swerve_odometry_accumulator_core_defines.svh"

module soa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);

    // A stalled result transaction keeps its valid and its positions.
    `SOA_ASSERT_NEXT(a_out_hold, aresetn && m_axis_tvalid && !m_axis_tready, !aresetn || (m_axis_tvalid && $stable(m_axis_tdata)), "stalled result changed")

    // The input side only backs up when a result is waiting at the output.
    `SOA_ASSERT_NOW(a_stall_cause, aresetn && !s_axis_tready, m_axis_tvalid, "input stalled with empty output")

    // Reset leaves no result pending.
    `SOA_ASSERT_NEXT(a_reset_empty, !aresetn, !m_axis_tvalid, "result valid after reset")

    // An idle input with a free output leaves the block ready the next cycle.
    `SOA_ASSERT_NEXT(a_ready_recovers, aresetn && !s_axis_tvalid && !m_axis_tvalid, s_axis_tready, "not ready while drained")

endmodule

bind swerve_odometry_accumulator_core soa_checker u_soa_checker (.*);
